/* hdl/lcdns_pkg.sv */
// ----------------------------------------------------------------------------
// LCD nibble sequencer package
// Shared word types, request kind codes, timing constants and the
// power-up initialization table for the 4-bit character LCD sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lcdns_pkg;

   // Field widths.
   localparam int unsigned KIND_W   = 3;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LINE_W   = 2;
   localparam int unsigned COL_W    = 4;
   localparam int unsigned NIB_W    = 4;
   localparam int unsigned BEFORE_W = 14;
   localparam int unsigned AFTER_W  = 11;
   localparam int unsigned STEP_W   = 4;

   // Request kind codes.
   localparam logic [KIND_W-1:0] KIND_CHAR  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CMD   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POS   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_INIT  = 3'd4;

   // Display command bytes.
   localparam logic [BYTE_W-1:0] CMD_CLEAR     = 8'h01;
   localparam logic [BYTE_W-1:0] CMD_FUNC_SET  = 8'h28;
   localparam logic [BYTE_W-1:0] CMD_DISP_ON   = 8'h0E;
   localparam logic [BYTE_W-1:0] CMD_ENTRY     = 8'h06;

   // Waits in microseconds.
   localparam logic [BEFORE_W-1:0] BYTE_LEAD_US = 14'd40;
   localparam logic [AFTER_W-1:0]  CLEAR_TAIL_US = 11'd2000;
   localparam logic [BEFORE_W-1:0] PWR_WAIT0_US = 14'd15000;
   localparam logic [BEFORE_W-1:0] PWR_WAIT1_US = 14'd5000;
   localparam logic [BEFORE_W-1:0] PWR_WAIT2_US = 14'd200;

   // Strobe indexes within an item.
   localparam logic [STEP_W-1:0] STEP_BYTE_LAST  = 4'd1;
   localparam logic [STEP_W-1:0] STEP_INIT_LAST  = 4'd11;
   localparam logic [STEP_W-1:0] STEP_INIT_BYTES = 4'd4;
   localparam logic [STEP_W-1:0] STEP_INIT_CLEAR = 4'd9;

   // Input word.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data_byte;
      logic [LINE_W-1:0] line;
      logic [COL_W-1:0]  column;
   } req_word_type;

   // Result word, one per enable strobe.
   typedef struct packed {
      logic                reg_select;
      logic [NIB_W-1:0]    nibble;
      logic [BEFORE_W-1:0] wait_before_us;
      logic [AFTER_W-1:0]  wait_after_us;
      logic                last;
   } rsp_word_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              load;
      logic              emit;
      logic [STEP_W-1:0] step;
      logic              last;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic is_byte;
      logic is_init;
   } dp_status_type;

   // Set-DDRAM-address base of each display line.
   function automatic logic [BYTE_W-1:0] line_base(input logic [LINE_W-1:0] line);
      logic [BYTE_W-1:0] base;
      unique case (line)
         2'd0: base = 8'h80;
         2'd1: base = 8'hC0;
         2'd2: base = 8'h90;
         2'd3: base = 8'hD0;
         default: base = 8'h80;
      endcase
      return base;
   endfunction

   // Command byte sent during the byte-wide part of initialization.
   function automatic logic [BYTE_W-1:0] init_byte(input logic [1:0] idx);
      logic [BYTE_W-1:0] b;
      unique case (idx)
         2'd0: b = CMD_FUNC_SET;
         2'd1: b = CMD_DISP_ON;
         2'd2: b = CMD_CLEAR;
         2'd3: b = CMD_ENTRY;
         default: b = CMD_ENTRY;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

/* hdl/lcdns_ctrl.sv */
// ----------------------------------------------------------------------------
// LCD nibble sequencer controller
// Takes one request at a time and steps the datapath through its strobes,
// one strobe per cycle whenever the output register can take a word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcdns_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire lcdns_pkg::dp_status_type status,
   output lcdns_pkg::dp_cmd_type       cmd
);
   import lcdns_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [STEP_W-1:0] final_step;
   logic              at_last;

   // The final strobe index depends on the request kind held in the datapath.
   assign final_step = status.is_init ? STEP_INIT_LAST : STEP_BYTE_LAST;
   assign at_last    = (step_ff == final_step);

   // Command outputs.
   always_comb begin
      cmd.load = (state_ff == ST_IDLE) && req_valid;
      cmd.emit = (state_ff == ST_EMIT) && (status.is_byte || status.is_init)
                 && status.out_free;
      cmd.step = step_ff;
      cmd.last = at_last;
   end

   assign req_stall = (state_ff != ST_IDLE);

   // Next state and step counter.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (req_valid) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Unknown kinds produce no strobes.
            if (!(status.is_byte || status.is_init)) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               if (at_last) begin
                  state_in = ST_IDLE;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/lcdns_dp.sv */
// ----------------------------------------------------------------------------
// LCD nibble sequencer datapath
// Holds the mode register, the current request and the output register, and
// forms each strobe word from the request and the step index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcdns_dp (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lcdns_pkg::req_word_type req_data,
   input  wire logic                    csr_write,
   input  wire logic                    csr_data,
   input  wire lcdns_pkg::dp_cmd_type   cmd,
   output lcdns_pkg::dp_status_type     status,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output lcdns_pkg::rsp_word_type      rsp_data
);
   import lcdns_pkg::*;

   logic          four_line_ff;
   req_word_type  req_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_ff, rsp_in;

   logic [LINE_W-1:0] eff_line;
   logic [BYTE_W-1:0] cur_byte;
   logic [1:0]        init_sel;
   logic              low_half;
   logic              clear_tail;
   logic              is_init;

   // Mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         four_line_ff <= 1'b0;
      end else if (csr_write) begin
         four_line_ff <= csr_data;
      end
   end

   // Request register.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   assign is_init = (req_ff.kind == KIND_INIT);

   always_comb begin
      status.out_free = !rsp_valid_ff || !rsp_stall;
      status.is_init  = is_init;
      status.is_byte  = (req_ff.kind == KIND_CHAR) || (req_ff.kind == KIND_CMD)
                        || (req_ff.kind == KIND_CLEAR) || (req_ff.kind == KIND_POS);
   end

   // Two-line mode folds lines 2 and 3 onto 0 and 1.
   assign eff_line = four_line_ff ? req_ff.line : {1'b0, req_ff.line[0]};

   // Index of the byte within the byte-wide part of initialization.
   assign init_sel = 2'((cmd.step - STEP_INIT_BYTES) >> 1);

   // Byte being sent at this step.
   always_comb begin
      cur_byte = req_ff.data_byte;
      if (is_init) begin
         cur_byte = init_byte(init_sel);
      end else if (req_ff.kind == KIND_CLEAR) begin
         cur_byte = CMD_CLEAR;
      end else if (req_ff.kind == KIND_POS) begin
         cur_byte = line_base(eff_line) + BYTE_W'(req_ff.column);
      end
   end

   // The low nibble of a byte goes out on odd steps in every kind.
   assign low_half   = cmd.step[0];
   assign clear_tail = (req_ff.kind == KIND_CLEAR) ||
                       (is_init && (cmd.step == STEP_INIT_CLEAR));

   // Strobe word for this step.
   always_comb begin
      rsp_in.reg_select     = (req_ff.kind == KIND_CHAR);
      rsp_in.last           = cmd.last;
      rsp_in.nibble         = low_half ? cur_byte[3:0] : cur_byte[7:4];
      rsp_in.wait_before_us = low_half ? '0 : BYTE_LEAD_US;
      rsp_in.wait_after_us  = (low_half && clear_tail) ? CLEAR_TAIL_US : '0;
      if (is_init && (cmd.step < STEP_INIT_BYTES)) begin
         // Power-up nibbles 3, 3, 3, 2 with their long waits.
         rsp_in.wait_after_us = '0;
         unique case (cmd.step[1:0])
            2'd0: begin
               rsp_in.nibble         = 4'h3;
               rsp_in.wait_before_us = PWR_WAIT0_US;
            end
            2'd1: begin
               rsp_in.nibble         = 4'h3;
               rsp_in.wait_before_us = PWR_WAIT1_US;
            end
            2'd2: begin
               rsp_in.nibble         = 4'h3;
               rsp_in.wait_before_us = PWR_WAIT2_US;
            end
            2'd3: begin
               rsp_in.nibble         = 4'h2;
               rsp_in.wait_before_us = PWR_WAIT2_US;
            end
            default: begin
               rsp_in.nibble         = 4'h2;
               rsp_in.wait_before_us = PWR_WAIT2_US;
            end
         endcase
      end
   end

   // Output register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

/* hdl/char_lcd_nibble_sequencer.sv */
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer
// Turns character, command, clear, cursor and power-up requests into the
// enable strobes of a 4-bit character LCD interface.
// ----------------------------------------------------------------------------
// One request word is taken at a time, in a cycle in which the block is idle.
// From the next cycle on it puts one strobe word per cycle into the output
// register while the result side does not stall: two strobes for a character,
// command, clear or cursor request and twelve for initialization, and none
// for an unknown kind. The strobe counter in the controller sets the number
// of strobes. Each strobe word carries RS, the nibble and the waits in
// microseconds that the pin driver must honor; the last strobe of a request
// is flagged. The mode register selects 16x2 or 16x4 line addressing; write
// it only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_sequencer (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire lcdns_pkg::req_word_type req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output lcdns_pkg::rsp_word_type      rsp_data,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic                    csr_data
);
   import lcdns_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // The mode register is always ready to take a write.
   assign csr_ready = 1'b1;

   lcdns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lcdns_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* tb/tb_char_lcd_nibble_sequencer.sv */
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer testbench
// Sends character, command, clear, cursor, power-up and unknown-kind requests in random
// bursts, predicts the enable strobe words of each request, and compares every
// strobe word that the result side takes with the oldest predicted word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_char_lcd_nibble_sequencer;
   import lcdns_pkg::*;

   localparam int unsigned RESET_CYCLES  = 8;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned CYCLE_LIMIT   = 300000;
   localparam int unsigned RANDOM_PHASES = 8;
   localparam int unsigned PHASE_ITEMS   = 50;

   // Styles of result-side stalling.
   localparam int unsigned STALL_NONE    = 0;
   localparam int unsigned STALL_LIGHT   = 1;
   localparam int unsigned STALL_PATTERN = 2;
   localparam int unsigned STALL_HEAVY   = 3;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_data  = 1'b0;

   // Shadow of the mode register and the strobe words still to arrive.
   logic         four_line_mode_q = 1'b0;
   rsp_word_type pending_strobes[$];
   rsp_word_type staged_strobes[$];

   int unsigned  error_count  = 0;
   int unsigned  cycle_count  = 0;
   int unsigned  burst_left   = 0;
   int unsigned  stall_left   = 0;
   int unsigned  stall_style  = STALL_NONE;
   logic [7:0]   stall_mask   = 8'h00;

   char_lcd_nibble_sequencer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   // Cycle counter with a hard limit on the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // The result side stalls in styles that change at random intervals.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style <= $urandom_range(STALL_NONE, STALL_HEAVY);
         stall_left  <= $urandom_range(32, 128);
         stall_mask  <= 8'($urandom_range(0, 255));
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_style)
         STALL_NONE:    rsp_stall <= 1'b0;
         STALL_LIGHT:   rsp_stall <= ($urandom_range(0, 2) == 0);
         STALL_PATTERN: rsp_stall <= stall_mask[cycle_count % 8];
         default:       rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Strobe word prediction.
   function automatic void stage_strobe(input logic rs, input logic [NIB_W-1:0] nib,
                                        input logic [BEFORE_W-1:0] lead,
                                        input logic [AFTER_W-1:0] after);
      rsp_word_type s;
      s.reg_select     = rs;
      s.nibble         = nib;
      s.wait_before_us = lead;
      s.wait_after_us  = after;
      s.last           = 1'b0;
      staged_strobes.push_back(s);
   endfunction

   // A byte goes out high nibble first, with the lead wait on that strobe.
   function automatic void stage_byte(input logic rs, input logic [BYTE_W-1:0] b,
                                      input logic [AFTER_W-1:0] after);
      stage_strobe(rs, b[7:4], BYTE_LEAD_US, '0);
      stage_strobe(rs, b[3:0], '0, after);
   endfunction

   function automatic void predict_strobes(input req_word_type w);
      logic [LINE_W-1:0] ln;
      logic [BYTE_W-1:0] addr;
      rsp_word_type      s;
      staged_strobes.delete();
      case (w.kind)
         KIND_CHAR:  stage_byte(1'b1, w.data_byte, '0);
         KIND_CMD:   stage_byte(1'b0, w.data_byte, '0);
         KIND_CLEAR: stage_byte(1'b0, CMD_CLEAR, CLEAR_TAIL_US);
         KIND_POS: begin
            // Two-line mode folds lines 2 and 3 onto lines 0 and 1.
            ln = four_line_mode_q ? w.line : {1'b0, w.line[0]};
            case (ln)
               2'd0:    addr = 8'h80;
               2'd1:    addr = 8'hC0;
               2'd2:    addr = 8'h90;
               default: addr = 8'hD0;
            endcase
            stage_byte(1'b0, addr + BYTE_W'(w.column), '0);
         end
         KIND_INIT: begin
            stage_strobe(1'b0, 4'h3, PWR_WAIT0_US, '0);
            stage_strobe(1'b0, 4'h3, PWR_WAIT1_US, '0);
            stage_strobe(1'b0, 4'h3, PWR_WAIT2_US, '0);
            stage_strobe(1'b0, 4'h2, PWR_WAIT2_US, '0);
            stage_byte(1'b0, CMD_FUNC_SET, '0);
            stage_byte(1'b0, CMD_DISP_ON, '0);
            stage_byte(1'b0, CMD_CLEAR, CLEAR_TAIL_US);
            stage_byte(1'b0, CMD_ENTRY, '0);
         end
         default: ;
      endcase
      if (staged_strobes.size() > 0) begin
         s = staged_strobes[staged_strobes.size() - 1];
         s.last = 1'b1;
         staged_strobes[staged_strobes.size() - 1] = s;
      end
      foreach (staged_strobes[i]) pending_strobes.push_back(staged_strobes[i]);
   endfunction

   task automatic check_field(input string name, input int unsigned exp_val,
                              input int unsigned act_val);
      if (exp_val != act_val) begin
         error_count++;
         $display("%0t: %s expected %0d, actual %0d", $time, name, exp_val, act_val);
      end
   endtask

   // Every strobe word taken is compared with the oldest prediction.
   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_strobes.size() == 0) begin
            error_count++;
            $display("%0t: strobe word expected none, actual %h", $time, rsp_data);
         end else begin
            exp_w = pending_strobes.pop_front();
            check_field("reg_select", 32'(exp_w.reg_select), 32'(rsp_data.reg_select));
            check_field("nibble", 32'(exp_w.nibble), 32'(rsp_data.nibble));
            check_field("wait_before_us", 32'(exp_w.wait_before_us),
                        32'(rsp_data.wait_before_us));
            check_field("wait_after_us", 32'(exp_w.wait_after_us),
                        32'(rsp_data.wait_after_us));
            check_field("last", 32'(exp_w.last), 32'(rsp_data.last));
         end
      end
   end

   // Sends one request word; the sender works in bursts with gaps between.
   task automatic send_request(input req_word_type w);
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      predict_strobes(w);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 7);
      end
   endtask

   // Drops the request side and waits until every strobe word has come.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_strobes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input logic mode);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      four_line_mode_q = mode;
   endtask

   function automatic req_word_type make_request(input logic [KIND_W-1:0] kind,
                                                 input logic [BYTE_W-1:0] b,
                                                 input logic [LINE_W-1:0] ln,
                                                 input logic [COL_W-1:0] col);
      req_word_type w;
      w.kind      = kind;
      w.data_byte = b;
      w.line      = ln;
      w.column    = col;
      return w;
   endfunction

   function automatic req_word_type random_request();
      int unsigned        pick;
      logic [KIND_W-1:0]  kind;
      pick = $urandom_range(0, 99);
      if (pick < 30)      kind = KIND_CHAR;
      else if (pick < 50) kind = KIND_CMD;
      else if (pick < 60) kind = KIND_CLEAR;
      else if (pick < 85) kind = KIND_POS;
      else if (pick < 93) kind = KIND_INIT;
      else                kind = KIND_INIT + KIND_W'($urandom_range(1, 3));
      return make_request(kind, BYTE_W'($urandom_range(0, 255)),
                          LINE_W'($urandom_range(0, 3)), COL_W'($urandom_range(0, 15)));
   endfunction

   task automatic test_characters();
      send_request(make_request(KIND_CHAR, 8'h00, 2'd0, 4'd0));
      send_request(make_request(KIND_CHAR, 8'hFF, 2'd3, 4'd15));
      send_request(make_request(KIND_CHAR, 8'h5A, 2'd1, 4'd5));
   endtask

   task automatic test_commands();
      send_request(make_request(KIND_CMD, 8'h00, 2'd3, 4'd15));
      send_request(make_request(KIND_CMD, 8'hFF, 2'd0, 4'd0));
      send_request(make_request(KIND_CMD, 8'hA5, 2'd2, 4'd10));
   endtask

   // Clear ignores its other fields and carries the long trailing wait.
   task automatic test_clear();
      send_request(make_request(KIND_CLEAR, 8'h00, 2'd0, 4'd0));
      send_request(make_request(KIND_CLEAR, 8'hFF, 2'd3, 4'd15));
   endtask

   // Cursor moves in both modes; two-line mode folds the upper lines.
   task automatic test_positions();
      int unsigned ln;
      set_mode(1'b0);
      for (ln = 0; ln < 4; ln++)
         send_request(make_request(KIND_POS, 8'hFF, LINE_W'(ln),
                                   ln[0] ? 4'd15 : 4'd0));
      set_mode(1'b1);
      for (ln = 0; ln < 4; ln++)
         send_request(make_request(KIND_POS, 8'h00, LINE_W'(ln),
                                   ln[0] ? 4'd0 : 4'd15));
   endtask

   task automatic test_init();
      send_request(make_request(KIND_INIT, 8'h00, 2'd0, 4'd0));
      send_request(make_request(KIND_INIT, 8'hFF, 2'd3, 4'd15));
   endtask

   // Kinds past the initialization code produce no strobes at all.
   task automatic test_unknown_kinds();
      int unsigned k;
      for (k = 1; k <= 3; k++)
         send_request(make_request(KIND_INIT + KIND_W'(k), 8'hFF, 2'd3, 4'd15));
      send_request(make_request(KIND_CHAR, 8'h3C, 2'd0, 4'd0));
   endtask

   task automatic test_random();
      int unsigned  phase;
      int unsigned  sent;
      req_word_type w;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase < 2) set_mode(phase == 0);
         else           set_mode(1'($urandom_range(0, 1)));
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            w = random_request();
            send_request(w);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_characters();
      test_commands();
      test_clear();
      test_positions();
      test_init();
      test_unknown_kinds();
      test_random();
      wait_idle();
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
